### src/gda_pkg.sv
// gda_pkg: shared types and constants of the gregorian date adder
// holds word structs, action codes and the control/status structs between
// controller and datapath; no dependencies
`timescale 1ns / 1ps

package gda_pkg;

  // calendar limits and offset width
  localparam int MAX_YEAR     = 9999;
  localparam int OFFSET_WIDTH = 16;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;
  localparam int OFS_W   = 16;

  // year split into century and year of century
  localparam int CENT_W = 8;
  localparam int YOC_W  = 7;

  // year length needs 9 bits, compare wide enough for both operands
  localparam int YLEN_W = 9;
  localparam int CMP_W  = (OFFSET_WIDTH > YLEN_W) ? OFFSET_WIDTH : YLEN_W;

  // year / 100 by reciprocal multiply, exact for all 14-bit years
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + 13;

  // reset date 2000-01-01, a saturday
  localparam int RST_DAY   = 1;
  localparam int RST_MONTH = 1;
  localparam int RST_YEAR  = 2000;
  localparam int RST_CENT  = RST_YEAR / 100;
  localparam int RST_YOC   = RST_YEAR % 100;
  localparam int RST_WDAY  = 6;

  // action codes
  localparam logic [1:0] ACT_SET = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;

  typedef struct packed {
    logic [1:0]               action;
    logic [DAY_W-1:0]         set_day;
    logic [MONTH_W-1:0]       set_month;
    logic [YEAR_W-1:0]        set_year;
    logic signed [OFS_W-1:0]  offset;
  } op_t;

  typedef struct packed {
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [WDAY_W-1:0]  weekday;
    logic               ok;
  } res_t;

  typedef struct packed {
    logic capture;
    logic conv_hi;
    logic conv_lo;
    logic check;
    logic step;
    logic wday;
    logic load_res;
  } ctl_cmd_t;

  typedef struct packed {
    logic rem_zero;
  } dp_status_t;

endpackage

### src/gda_datapath.sv
// gda_datapath: date registers, set conversion, day stepping and weekday unit
// driven by ctl_cmd_t from gda_ctrl; uses gda_pkg
`timescale 1ns / 1ps

module gda_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  gda_pkg::op_t          op,
  input  gda_pkg::ctl_cmd_t     cmd,
  output gda_pkg::dp_status_t   status,
  output gda_pkg::res_t         res
);

  localparam logic [gda_pkg::MONTH_W-1:0] MON_JAN = gda_pkg::MONTH_W'(1);
  localparam logic [gda_pkg::MONTH_W-1:0] MON_FEB = gda_pkg::MONTH_W'(2);
  localparam logic [gda_pkg::MONTH_W-1:0] MON_DEC = gda_pkg::MONTH_W'(12);
  localparam logic [gda_pkg::YEAR_W-1:0]  YEAR_MAX = gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR);
  localparam logic [gda_pkg::YOC_W-1:0]   YOC_LAST = gda_pkg::YOC_W'(99);

  function automatic logic is_leap(logic [gda_pkg::CENT_W-1:0] c,
                                   logic [gda_pkg::YOC_W-1:0] yc);
    return (yc[1:0] == 2'd0) && ((yc != '0) || (c[1:0] == 2'd0));
  endfunction

  function automatic logic [gda_pkg::DAY_W-1:0] month_len(
      logic [gda_pkg::MONTH_W-1:0] m, logic leap);
    logic [gda_pkg::DAY_W-1:0] n;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // floor(13 * (m + 1) / 5), january and february as months 13 and 14
  function automatic logic [5:0] zeller_month(logic [gda_pkg::MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      default: t = 6'd33;
    endcase
    return t;
  endfunction

  // octal digit fold, 8 = 1 mod 7
  function automatic logic [2:0] mod7(logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // zeller code (0 saturday) to iso weekday
  function automatic logic [gda_pkg::WDAY_W-1:0] iso_day(logic [2:0] h);
    logic [gda_pkg::WDAY_W-1:0] w;
    case (h)
      3'd0:    w = 3'd6;
      3'd1:    w = 3'd7;
      3'd2:    w = 3'd1;
      3'd3:    w = 3'd2;
      3'd4:    w = 3'd3;
      3'd5:    w = 3'd4;
      default: w = 3'd5;
    endcase
    return w;
  endfunction

  // current date, year kept both binary and as century / year of century
  logic [gda_pkg::DAY_W-1:0]   day, day_next;
  logic [gda_pkg::MONTH_W-1:0] month, month_next;
  logic [gda_pkg::YEAR_W-1:0]  year, year_next;
  logic [gda_pkg::CENT_W-1:0]  cent, cent_next;
  logic [gda_pkg::YOC_W-1:0]   yoc, yoc_next;
  logic [gda_pkg::WDAY_W-1:0]  wday;
  logic                        ok, ok_next;

  // captured set fields and their century split
  logic [gda_pkg::DAY_W-1:0]   set_day_r;
  logic [gda_pkg::MONTH_W-1:0] set_month_r;
  logic [gda_pkg::YEAR_W-1:0]  set_year_r;
  logic [gda_pkg::CENT_W-1:0]  conv_c;
  logic [gda_pkg::YOC_W-1:0]   conv_yc;
  logic [gda_pkg::PROD_W-1:0]  div_prod;
  logic [gda_pkg::YEAR_W-1:0]  yoc_wide;
  logic                        set_valid;

  // remaining day count and direction
  logic [gda_pkg::OFFSET_WIDTH-1:0] rem, rem_next;
  logic                             back;
  logic [gda_pkg::OFFSET_WIDTH-1:0] off_ext, off_mag;
  logic [gda_pkg::CMP_W-1:0]        rem_x;

  // neighbor years and month lengths
  logic [gda_pkg::CENT_W-1:0] cent_inc, cent_dec;
  logic [gda_pkg::YOC_W-1:0]  yoc_inc, yoc_dec;
  logic                       leap_cur, leap_nx, leap_pv;
  logic [gda_pkg::DAY_W-1:0]  ml_cur, ml_prev, ml_pvy;
  logic [gda_pkg::YLEN_W-1:0] ylen_f, ylen_b;
  logic [gda_pkg::DAY_W:0]    to_next;

  // weekday terms
  logic [gda_pkg::YOC_W-1:0]  k_val;
  logic [gda_pkg::CENT_W-1:0] j_val;
  logic [10:0]                wsum;

  assign off_ext = gda_pkg::OFFSET_WIDTH'(signed'(op.offset));
  assign off_mag = off_ext[gda_pkg::OFFSET_WIDTH-1] ? (~off_ext + 1'b1) : off_ext;
  assign rem_x   = gda_pkg::CMP_W'(rem);
  assign status.rem_zero = (rem == '0);

  // set path: year / 100, then year mod 100, then range checks
  assign div_prod = gda_pkg::PROD_W'(set_year_r) * gda_pkg::PROD_W'(gda_pkg::DIV100_MUL);
  assign yoc_wide = set_year_r - gda_pkg::YEAR_W'(conv_c) * gda_pkg::YEAR_W'(100);
  assign set_valid = (set_month_r >= MON_JAN) && (set_month_r <= MON_DEC) &&
                     (set_year_r <= YEAR_MAX) && (set_day_r != '0) &&
                     (set_day_r <= month_len(set_month_r, is_leap(conv_c, conv_yc)));

  always_comb begin
    if (yoc == YOC_LAST) begin
      yoc_inc  = '0;
      cent_inc = cent + 1'b1;
    end else begin
      yoc_inc  = yoc + 1'b1;
      cent_inc = cent;
    end
    if (yoc == '0) begin
      yoc_dec  = YOC_LAST;
      cent_dec = cent - 1'b1;
    end else begin
      yoc_dec  = yoc - 1'b1;
      cent_dec = cent;
    end
  end

  assign leap_cur = is_leap(cent, yoc);
  assign leap_nx  = is_leap(cent_inc, yoc_inc);
  assign leap_pv  = is_leap(cent_dec, yoc_dec);
  assign ml_cur   = month_len(month, leap_cur);
  assign ml_prev  = (month == MON_JAN) ? 5'd31 : month_len(month - 1'b1, leap_cur);
  assign ml_pvy   = month_len(month, leap_pv);
  assign to_next  = {1'b0, ml_cur} - {1'b0, day} + 1'b1;
  // first of month to same first next year, last of month to same last a year ago
  assign ylen_f = 9'd365 + 9'(((month <= MON_FEB) ? leap_cur : leap_nx));
  assign ylen_b = 9'd365 + 9'(((month >= MON_FEB) ? leap_cur : leap_pv));

  // one stepping move: a whole year, a month boundary, or the final days
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    cent_next  = cent;
    yoc_next   = yoc;
    rem_next   = rem;
    ok_next    = ok;
    if (!back) begin
      if ((day == 5'd1) && (year < YEAR_MAX) &&
          (rem_x >= gda_pkg::CMP_W'(ylen_f))) begin
        year_next = year + 1'b1;
        cent_next = cent_inc;
        yoc_next  = yoc_inc;
        rem_next  = gda_pkg::OFFSET_WIDTH'(rem_x - gda_pkg::CMP_W'(ylen_f));
      end else if (rem_x >= gda_pkg::CMP_W'(to_next)) begin
        if ((month == MON_DEC) && (year == YEAR_MAX)) begin
          day_next = 5'd31;
          rem_next = '0;
          ok_next  = 1'b0;
        end else begin
          day_next = 5'd1;
          rem_next = gda_pkg::OFFSET_WIDTH'(rem_x - gda_pkg::CMP_W'(to_next));
          if (month == MON_DEC) begin
            month_next = MON_JAN;
            year_next  = year + 1'b1;
            cent_next  = cent_inc;
            yoc_next   = yoc_inc;
          end else begin
            month_next = month + 1'b1;
          end
        end
      end else begin
        day_next = day + rem[gda_pkg::DAY_W-1:0];
        rem_next = '0;
      end
    end else begin
      if ((day == ml_cur) && (year != '0) &&
          (rem_x >= gda_pkg::CMP_W'(ylen_b))) begin
        year_next = year - 1'b1;
        cent_next = cent_dec;
        yoc_next  = yoc_dec;
        day_next  = ml_pvy;
        rem_next  = gda_pkg::OFFSET_WIDTH'(rem_x - gda_pkg::CMP_W'(ylen_b));
      end else if (rem_x >= gda_pkg::CMP_W'(day)) begin
        if ((month == MON_JAN) && (year == '0)) begin
          day_next = 5'd1;
          rem_next = '0;
          ok_next  = 1'b0;
        end else begin
          day_next = ml_prev;
          rem_next = gda_pkg::OFFSET_WIDTH'(rem_x - gda_pkg::CMP_W'(day));
          if (month == MON_JAN) begin
            month_next = MON_DEC;
            year_next  = year - 1'b1;
            cent_next  = cent_dec;
            yoc_next   = yoc_dec;
          end else begin
            month_next = month - 1'b1;
          end
        end
      end else begin
        day_next = day - rem[gda_pkg::DAY_W-1:0];
        rem_next = '0;
      end
    end
  end

  // zeller congruence, year shifted by 400 so january of year 0 stays positive
  always_comb begin
    if (month <= MON_FEB) begin
      if (yoc == '0) begin
        k_val = YOC_LAST;
        j_val = cent + 8'd3;
      end else begin
        k_val = yoc - 1'b1;
        j_val = cent + 8'd4;
      end
    end else begin
      k_val = yoc;
      j_val = cent + 8'd4;
    end
  end

  assign wsum = 11'(day) + 11'(zeller_month(month)) + 11'(k_val) + 11'(k_val >> 2) +
                11'(j_val >> 2) + 11'(j_val) * 11'd5;

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= gda_pkg::DAY_W'(gda_pkg::RST_DAY);
      month <= gda_pkg::MONTH_W'(gda_pkg::RST_MONTH);
      year  <= gda_pkg::YEAR_W'(gda_pkg::RST_YEAR);
      cent  <= gda_pkg::CENT_W'(gda_pkg::RST_CENT);
      yoc   <= gda_pkg::YOC_W'(gda_pkg::RST_YOC);
      wday  <= gda_pkg::WDAY_W'(gda_pkg::RST_WDAY);
    end else begin
      if (cmd.check && set_valid) begin
        day   <= set_day_r;
        month <= set_month_r;
        year  <= set_year_r;
        cent  <= conv_c;
        yoc   <= conv_yc;
      end else if (cmd.step) begin
        day   <= day_next;
        month <= month_next;
        year  <= year_next;
        cent  <= cent_next;
        yoc   <= yoc_next;
      end
      if (cmd.wday) begin
        wday <= iso_day(mod7(wsum));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_day_r   <= op.set_day;
      set_month_r <= op.set_month;
      set_year_r  <= op.set_year;
      rem         <= off_mag;
      back        <= off_ext[gda_pkg::OFFSET_WIDTH-1];
      ok          <= 1'b1;
    end else if (cmd.step) begin
      rem <= rem_next;
      ok  <= ok_next;
    end else if (cmd.check && !set_valid) begin
      ok <= 1'b0;
    end
    if (cmd.conv_hi) begin
      conv_c <= div_prod[gda_pkg::DIV100_SHIFT +: gda_pkg::CENT_W];
    end
    if (cmd.conv_lo) begin
      conv_yc <= yoc_wide[gda_pkg::YOC_W-1:0];
    end
    if (cmd.load_res) begin
      res.out_day   <= day;
      res.out_month <= month;
      res.out_year  <= year;
      res.weekday   <= wday;
      res.ok        <= ok;
    end
  end

endmodule

### src/gda_ctrl.sv
// gda_ctrl: sequencer of the gregorian date adder
// issues ctl_cmd_t to gda_datapath and owns the handshake; uses gda_pkg
`timescale 1ns / 1ps

module gda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  logic [1:0]           action,
  output logic                 op_stall,
  output logic                 res_valid,
  input  logic                 res_stall,
  input  gda_pkg::dp_status_t  status,
  output gda_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV_HI,
    S_CONV_LO,
    S_CHECK,
    S_STEP,
    S_WDAY,
    S_DELIVER
  } state_t;

  state_t state;

  assign op_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && op_valid;
    cmd.conv_hi  = (state == S_CONV_HI);
    cmd.conv_lo  = (state == S_CONV_LO);
    cmd.check    = (state == S_CHECK);
    cmd.step     = (state == S_STEP) && !status.rem_zero;
    cmd.wday     = (state == S_WDAY);
    cmd.load_res = (state == S_DELIVER) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (op_valid) begin
            if (action == gda_pkg::ACT_SET) begin
              state <= S_CONV_HI;
            end else if (action == gda_pkg::ACT_ADD) begin
              state <= S_STEP;
            end else begin
              state <= S_DELIVER;
            end
          end
        end
        S_CONV_HI: state <= S_CONV_LO;
        S_CONV_LO: state <= S_CHECK;
        S_CHECK:   state <= S_WDAY;
        S_STEP: begin
          if (status.rem_zero) begin
            state <= S_WDAY;
          end
        end
        S_WDAY: state <= S_DELIVER;
        S_DELIVER: begin
          if (cmd.load_res) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/gregorian_date_adder.sv
// gregorian_date_adder: top level, joins gda_ctrl and gda_datapath
// depends on gda_pkg, gda_ctrl and gda_datapath
`timescale 1ns / 1ps

// Keeps one Gregorian date (reset 2000-01-01) and answers every input word
// with one result word: the date after the action, its ISO weekday and an ok
// flag. A set word loads a date only if it is a real calendar date with a
// year up to MAX_YEAR; an add word moves the date by a signed day offset and
// clamps at 0000-01-01 or MAX_YEAR-12-31 with ok low; any other action just
// reports. One word is worked at a time; the next word is taken once the
// current one has its result queued in the output register, even while that
// result still waits to be taken. An add steps through the calendar one
// move per cycle: a whole year while the remaining count allows, else one
// month boundary, else the final days, so it takes about |offset|/365 year
// moves plus at most 14 month and day moves. The weekday is computed fresh
// after each set or add.

module gregorian_date_adder (
  input  logic            clk,
  input  logic            rst,
  // input words
  input  logic            op_valid,
  output logic            op_stall,
  input  gda_pkg::op_t    op,
  // result words
  output logic            res_valid,
  input  logic            res_stall,
  output gda_pkg::res_t   res
);

  // commands down to the datapath, status back up
  gda_pkg::ctl_cmd_t   cmd;
  gda_pkg::dp_status_t status;

  // sequencer: handshakes, set conversion, stepping loop, weekday, delivery
  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .action    (op.action),
    .op_stall  (op_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // date registers, step logic and the output register
  gda_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .cmd    (cmd),
    .status (status),
    .res    (res)
  );

endmodule

### verif/gregorian_date_adder_tb.sv
// gregorian_date_adder_tb: self-checking bench for the gregorian date adder
// uses a calendar predictor and random bursty traffic; depends on gda_pkg and gregorian_date_adder
`timescale 1ns / 1ps

module gregorian_date_adder_tb;

  // action codes the package leaves unnamed
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_WORDS = 1025;
  localparam int IDLE_LIMIT   = 3000;   // longer than the longest add and the receiver hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_CAP    = 100;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          op_valid  = 1'b0;
  logic          op_stall;
  gda_pkg::op_t  op        = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  gda_pkg::res_t res;

  gregorian_date_adder uut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  // predicted date register
  int cal_day   = gda_pkg::RST_DAY;
  int cal_month = gda_pkg::RST_MONTH;
  int cal_year  = gda_pkg::RST_YEAR;

  gda_pkg::op_t  words_to_send[$];
  gda_pkg::res_t expected_dates[$];

  int   mismatches      = 0;
  int   words_taken     = 0;
  int   results_checked = 0;
  int   n_sets          = 0;
  int   n_rejected      = 0;
  int   n_adds          = 0;
  int   n_clamped       = 0;
  int   n_queries       = 0;
  logic op_fired        = 1'b0;

  // ------------------------------------------------------------------
  // calendar arithmetic
  // ------------------------------------------------------------------
  function automatic bit is_leap(int y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int days_in_month(int m, int y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return is_leap(y) ? 29 : 28;
    return 31;
  endfunction

  // day count from march 1 of year -400, so every legal date is positive
  function automatic longint day_number(int d, int m, int y);
    longint yy;
    longint mp;
    yy = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
    mp = longint'((m + 9) % 12);
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + longint'(d) - 1;
  endfunction

  function automatic void number_to_date(longint z, output int d, output int m,
                                         output int y);
    longint era, doe, yoe, doy, mp, mm;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = int'(doy - (153 * mp + 2) / 5 + 1);
    mm  = (mp < 10) ? mp + 3 : mp - 9;
    m   = int'(mm);
    y   = int'(yoe + era * 400 + ((mm <= 2) ? 1 : 0) - 400);
  endfunction

  // applies one word to the predicted date and returns the result word it gives
  function automatic gda_pkg::res_t apply_word(gda_pkg::op_t w);
    gda_pkg::res_t r;
    bit            good;
    longint        target;
    longint        lo;
    longint        hi;
    longint        wd;
    good = 1'b1;
    case (w.action)
      gda_pkg::ACT_SET: begin
        n_sets++;
        if (w.set_month >= 1 && w.set_month <= 12 && w.set_year <= gda_pkg::MAX_YEAR &&
            w.set_day >= 1 &&
            w.set_day <= days_in_month(int'(w.set_month), int'(w.set_year))) begin
          cal_day   = int'(w.set_day);
          cal_month = int'(w.set_month);
          cal_year  = int'(w.set_year);
        end else begin
          good = 1'b0;
          n_rejected++;
        end
      end
      gda_pkg::ACT_ADD: begin
        n_adds++;
        // offset field is exactly OFFSET_WIDTH bits, so plain sign extension
        target = day_number(cal_day, cal_month, cal_year) + longint'($signed(w.offset));
        lo = day_number(1, 1, 0);
        hi = day_number(31, 12, gda_pkg::MAX_YEAR);
        if (target < lo) begin
          target = lo;
          good = 1'b0;
        end
        if (target > hi) begin
          target = hi;
          good = 1'b0;
        end
        if (!good) n_clamped++;
        number_to_date(target, cal_day, cal_month, cal_year);
      end
      default: n_queries++;
    endcase
    // 2000-01-01 is a saturday, iso 6
    wd = (day_number(cal_day, cal_month, cal_year) - day_number(1, 1, 2000)) % 7;
    wd = (wd + 7) % 7;
    wd = (wd + 5) % 7 + 1;
    r.out_day   = cal_day[gda_pkg::DAY_W-1:0];
    r.out_month = cal_month[gda_pkg::MONTH_W-1:0];
    r.out_year  = cal_year[gda_pkg::YEAR_W-1:0];
    r.weekday   = wd[gda_pkg::WDAY_W-1:0];
    r.ok        = good;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  function automatic gda_pkg::op_t make_word(logic [1:0] act, int d, int m, int y, int off);
    gda_pkg::op_t w;
    w.action    = act;
    w.set_day   = d[gda_pkg::DAY_W-1:0];
    w.set_month = m[gda_pkg::MONTH_W-1:0];
    w.set_year  = y[gda_pkg::YEAR_W-1:0];
    w.offset    = off[gda_pkg::OFS_W-1:0];
    return w;
  endfunction

  // junk in the fields an action ignores
  function automatic gda_pkg::op_t noise_word(logic [1:0] act);
    return make_word(act, $urandom_range(0, 31), $urandom_range(0, 15),
                     $urandom_range(0, 16383), $urandom);
  endfunction

  // years biased toward the ends of the range and century boundaries
  function automatic int pick_year();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(gda_pkg::MAX_YEAR - 3, gda_pkg::MAX_YEAR);
      2: return 100 * $urandom_range(0, gda_pkg::MAX_YEAR / 100);
      3: return $urandom_range(1890, 2110);
      default: return $urandom_range(0, gda_pkg::MAX_YEAR);
    endcase
  endfunction

  function automatic gda_pkg::op_t valid_set_word();
    gda_pkg::op_t w;
    int           y;
    int           m;
    int           d;
    y = pick_year();
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? days_in_month(m, y)
                                    : $urandom_range(1, days_in_month(m, y));
    w = noise_word(gda_pkg::ACT_SET);
    w.set_year  = y[gda_pkg::YEAR_W-1:0];
    w.set_month = m[gda_pkg::MONTH_W-1:0];
    w.set_day   = d[gda_pkg::DAY_W-1:0];
    return w;
  endfunction

  function automatic gda_pkg::op_t add_word();
    gda_pkg::op_t w;
    int           r;
    int           off;
    r = $urandom_range(0, 9);
    if (r < 5)      off = $urandom_range(0, 800) - 400;     // crosses months
    else if (r < 8) off = $urandom_range(0, 10000) - 5000;  // crosses years
    else            off = int'($signed(16'($urandom)));       // full range
    w = noise_word(gda_pkg::ACT_ADD);
    w.offset = off[gda_pkg::OFS_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    // cap the log, the count still runs
    if (mismatches <= PRINT_CAP)
      $display("%0t: mismatch at result %0d: %s got %0d want %0d",
               $realtime, results_checked, what, got, want);
  endtask

  // ------------------------------------------------------------------
  // driver: bursts of words with random gaps, changes on the falling edge
  // ------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (!op_valid || op_fired) begin
      // current word went through (or nothing offered): next word or a gap
      if (gap_left > 0) begin
        gap_left--;
        op_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        op       <= words_to_send.pop_front();
        op_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          // no-gap stretches as well as long pauses
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver stall pattern, plus one long hold-off so the input backs up
  // ------------------------------------------------------------------
  int  stall_mode  = 0;
  int  mode_left   = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  int  stall_phase = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (!hold_done && words_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 200);
      end
      mode_left--;
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= (stall_phase % 3 == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: predict on every accepted input word, check every result word
  // ------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    gda_pkg::res_t want;
    if (rst) begin
      op_fired <= 1'b0;
    end else begin
      op_fired <= op_valid && !op_stall;
      if (op_valid && !op_stall) begin
        expected_dates.push_back(apply_word(op));
        words_taken++;
      end
      if (res_valid && !res_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with nothing pending, year", int'(res.out_year), -1);
        end else begin
          want = expected_dates.pop_front();
          if (res.out_day !== want.out_day)
            report_mismatch("out_day", int'(res.out_day), int'(want.out_day));
          if (res.out_month !== want.out_month)
            report_mismatch("out_month", int'(res.out_month), int'(want.out_month));
          if (res.out_year !== want.out_year)
            report_mismatch("out_year", int'(res.out_year), int'(want.out_year));
          if (res.weekday !== want.weekday)
            report_mismatch("weekday", int'(res.weekday), int'(want.weekday));
          if (res.ok !== want.ok)
            report_mismatch("ok", int'(res.ok), int'(want.ok));
          results_checked++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog: ends the run after too long with no word moving either way
  // ------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (op_valid && !op_stall) || (res_valid && !res_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin : sequencer
    int r;
    // directed: reset date, range ends, leap rules, bad fields, odd actions
    words_to_send.push_back(make_word(ACT_QUERY, 0, 0, 0, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 1, 1, 0, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, -1));     // clamps low
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 29, 2, 0, 0));     // year 0 is leap
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 31, 12, gda_pkg::MAX_YEAR, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, 1));      // clamps high
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 31, 15, 16383, -32768));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, 32767));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 29, 2, 2000, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 29, 2, 1900, 0));  // century, not leap
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 29, 2, 2004, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 29, 2, 2001, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 10, 0, 2010, 0));  // month zero
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 10, 13, 2010, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 31, 15, 16383, -1)); // all ones
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 0, 5, 2010, 0));   // day zero
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 31, 4, 2010, 0));  // past month end
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 1, 1, gda_pkg::MAX_YEAR + 1, 0));
    words_to_send.push_back(make_word(ACT_SPARE, 31, 15, 16383, -1));
    words_to_send.push_back(make_word(ACT_QUERY, 31, 15, 16383, -1));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 31, 15, 16383, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 31, 12, 1999, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, 1));      // year rollover
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, -366));
    words_to_send.push_back(make_word(gda_pkg::ACT_SET, 15, 6, 3, 0));
    words_to_send.push_back(make_word(gda_pkg::ACT_ADD, 0, 0, 0, -32768)); // clamps low

    // random: mostly legal sets and adds, some bad sets and queries
    repeat (RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 30)      words_to_send.push_back(valid_set_word());
      else if (r < 40) words_to_send.push_back(noise_word(gda_pkg::ACT_SET));
      else if (r < 88) words_to_send.push_back(add_word());
      else if (r < 96) words_to_send.push_back(noise_word(ACT_QUERY));
      else             words_to_send.push_back(noise_word(ACT_SPARE));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_to_send.size() != 0 || op_valid) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0)
      report_mismatch("results never returned", 0, expected_dates.size());

    $display("run covered %0d words: %0d sets (%0d rejected), %0d adds (%0d clamped),",
             words_taken, n_sets, n_rejected, n_adds, n_clamped);
    $display("%0d queries; %0d result words checked, %0d mismatches",
             n_queries, results_checked, mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
